FILE: hdl/s256_pkg.sv
// Package: shared types, constants and round functions for the SHA-256 byte hasher.
// No dependencies.
`timescale 1ns / 1ps
package s256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned FillW      = 6;
  localparam int unsigned TotalW     = 61;
  localparam int unsigned WordW      = 32;
  localparam int unsigned WordIdxW   = 3;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_RUN,
    ST_ADD,
    ST_OUT
  } state_e;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] start_h(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: hdl/s256_if.sv
// Interfaces: valid/ready channels for message bytes and digest words.
// Depends on nothing.
`timescale 1ns / 1ps
interface s256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;
  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface s256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;
  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

FILE: hdl/s256_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module s256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: hdl/s256_core.sv
// Compression core: schedule window, working registers, a round per load_i cycle.
// Depends on s256_pkg.
`timescale 1ns / 1ps
module s256_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,   // shift in one message word, rounds on it
  input  logic        init_i,   // copy chain words into working set
  input  logic [31:0] w_i,
  input  logic [31:0] h_i [8],
  input  logic [5:0]  round_i,
  output logic [31:0] v_o [8]
);
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] wt, s0, s1, t1, t2, e, a;

  always_comb begin
    s0 = s256_pkg::rotr(w_q[1], 7) ^ s256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = s256_pkg::rotr(w_q[14], 17) ^ s256_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wt = (round_i < 6'd16) ? w_i : (s1 + w_q[9] + s0 + w_q[0]);
    e  = v_q[4];
    a  = v_q[0];
    t1 = v_q[7] + (s256_pkg::rotr(e, 6) ^ s256_pkg::rotr(e, 11) ^ s256_pkg::rotr(e, 25))
       + ((e & v_q[5]) ^ (~e & v_q[6])) + s256_pkg::round_k(round_i) + wt;
    t2 = (s256_pkg::rotr(a, 2) ^ s256_pkg::rotr(a, 13) ^ s256_pkg::rotr(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) v_q[i] <= '0;
      for (int i = 0; i < 16; i++) w_q[i] <= '0;
    end else if (init_i) begin
      v_q <= h_i;
    end else if (load_i) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign v_o = v_q;
endmodule

FILE: hdl/sha256_byte_stream_hasher.sv
// Top level: SHA-256 byte-stream hasher with block buffer in RAM (4 bytes wide x 16).
// Depends on s256_pkg, s256_if, s256_ram, s256_core.
//
//  channel | dir | payload                               | handshake
//  in_if   | in  | data_byte, byte_present, last_byte    | valid/ready
//  out_if  | out | digest_word, word_index, final_word   | valid/ready
//
// A byte that does not fill a block is written to its RAM word as it is accepted.
// A byte that fills a block starts a block pass: a read-prime state, 64 rounds of the
// one-round-per-cycle core with the RAM reads overlapped, then chain add. Closing
// writes the pad and zero fill one RAM word per cycle (up to 16), two length words
// and a block pass, plus a second block when the pad lands past byte 55, then eight
// digest words, one per accepted output cycle. Reset is asynchronous and leaves the
// block idle with initial chain words; an output stall holds the digest.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
  input logic clk_i,
  input logic rst_ni,
  s256_in_if.sink    in_if,
  s256_out_if.source out_if
);
  s256_pkg::state_e state_q, state_d;

  logic [31:0] h_q [8];
  logic [5:0]  fill_q, fill_d;
  logic [60:0] total_q, total_d;
  logic        last_q, last_d;     // message closing
  logic        two_q, two_d;       // padding needs a second block
  logic        padded_q, padded_d; // pad byte already placed
  logic [6:0]  cnt_q, cnt_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [31:0] cur_q, cur_d;       // current partially built word

  // RAM: 16 words of 32 bits
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [31:0] v [8];
  logic        core_load, core_init, add;
  logic [63:0] bits;
  logic [5:0]  rnd;
  logic        acc;

  s256_ram #(.Width(32), .Depth(16)) u_buf (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  s256_core u_core (
    .clk_i, .rst_ni, .load_i(core_load), .init_i(core_init),
    .w_i(rdata), .h_i(h_q), .round_i(rnd), .v_o(v)
  );

  assign acc  = in_if.valid && in_if.ready;
  assign bits = {total_q, 3'b000};
  assign rnd  = cnt_q[5:0] - 6'd1;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    total_d   = total_q;
    last_d    = last_q;
    two_d     = two_q;
    padded_d  = padded_q;
    cnt_d     = cnt_q;
    oidx_d    = oidx_q;
    cur_d     = cur_q;
    we        = 1'b0;
    waddr     = fill_q[5:2];
    wdata     = '0;
    raddr     = '0;
    core_load = 1'b0;
    core_init = 1'b0;
    add       = 1'b0;
    in_if.ready  = 1'b0;
    out_if.valid = 1'b0;
    unique case (state_q)
      s256_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (acc) begin
          if (in_if.byte_present) begin
            unique case (fill_q[1:0])
              2'd0: cur_d = {in_if.data_byte, 24'h0};
              2'd1: cur_d = {cur_q[31:24], in_if.data_byte, 16'h0};
              2'd2: cur_d = {cur_q[31:16], in_if.data_byte, 8'h0};
              default: cur_d = {cur_q[31:8], in_if.data_byte};
            endcase
            we     = 1'b1;
            wdata  = cur_d;
            fill_d = fill_q + 6'd1;
          end
          last_d = in_if.last_byte;
          if (in_if.byte_present && fill_q == 6'd63) begin
            total_d   = total_q + 61'd64;
            state_d   = s256_pkg::ST_LOAD;
            cnt_d     = '0;
            padded_d  = 1'b0;
            core_init = 1'b1;
          end else if (in_if.last_byte) begin
            state_d  = s256_pkg::ST_PAD;
            padded_d = 1'b0;
          end
        end
      end
      s256_pkg::ST_PAD: begin
        // place pad byte then zero the rest, one word per cycle
        if (!padded_q) begin
          unique case (fill_q[1:0])
            2'd0: wdata = {s256_pkg::PadByte, 24'h0};
            2'd1: wdata = {cur_q[31:24], s256_pkg::PadByte, 16'h0};
            2'd2: wdata = {cur_q[31:16], s256_pkg::PadByte, 8'h0};
            default: wdata = {cur_q[31:8], s256_pkg::PadByte};
          endcase
          total_d  = total_q + 61'(fill_q);
          two_d    = fill_q > 6'd55;
          padded_d = 1'b1;
        end else begin
          wdata = '0;
        end
        we     = 1'b1;
        waddr  = fill_q[5:2];
        fill_d = {fill_q[5:2] + 4'd1, 2'b00};
        if (fill_q[5:2] == 4'd15) begin
          fill_d = fill_q;
          if (two_d) begin
            state_d   = s256_pkg::ST_LOAD;
            cnt_d     = '0;
            core_init = 1'b1;
          end else begin
            cnt_d   = '0;
            state_d = s256_pkg::ST_LEN;
          end
        end
      end
      s256_pkg::ST_LEN: begin
        we = 1'b1;
        if (cnt_q[0] == 1'b0) begin
          waddr = 4'd14;
          wdata = bits[63:32];
          cnt_d = 7'd1;
        end else begin
          waddr     = 4'd15;
          wdata     = bits[31:0];
          two_d     = 1'b0;
          cnt_d     = '0;
          state_d   = s256_pkg::ST_LOAD;
          core_init = 1'b1;
        end
      end
      s256_pkg::ST_LOAD: begin
        // prime first RAM read
        raddr   = 4'd0;
        cnt_d   = 7'd1;
        state_d = s256_pkg::ST_RUN;
      end
      s256_pkg::ST_RUN: begin
        raddr     = cnt_q[3:0];
        core_load = 1'b1;
        cnt_d     = cnt_q + 7'd1;
        if (cnt_q == 7'd64) state_d = s256_pkg::ST_ADD;
      end
      s256_pkg::ST_ADD: begin
        add = 1'b1;
        if (!last_q) begin
          state_d = s256_pkg::ST_IDLE;
          fill_d  = '0;
        end else if (!padded_q) begin
          // last byte filled the block: pad into a fresh block
          fill_d  = '0;
          state_d = s256_pkg::ST_PAD;
        end else if (two_q) begin
          // second padding block: clear all, then length
          two_d    = 1'b0;
          fill_d   = '0;
          padded_d = 1'b1;
          state_d  = s256_pkg::ST_PAD;
        end else begin
          oidx_d  = '0;
          state_d = s256_pkg::ST_OUT;
        end
      end
      s256_pkg::ST_OUT: begin
        out_if.valid = 1'b1;
        if (out_if.ready) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            state_d = s256_pkg::ST_IDLE;
            fill_d  = '0;
            total_d = '0;
            last_d  = 1'b0;
          end
        end
      end
      default: state_d = s256_pkg::ST_IDLE;
    endcase
  end

  // second block: two_q set in ST_PAD means pad was in block one; ST_ADD clears the flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= s256_pkg::ST_IDLE;
      fill_q   <= '0;
      total_q  <= '0;
      last_q   <= 1'b0;
      two_q    <= 1'b0;
      padded_q <= 1'b0;
      cnt_q    <= '0;
      oidx_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= s256_pkg::start_h(3'(i));
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      total_q  <= total_d;
      last_q   <= last_d;
      two_q    <= two_d;
      padded_q <= padded_d;
      cnt_q    <= cnt_d;
      oidx_q   <= oidx_d;
      if (add) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v[i];
      end else if (state_q == s256_pkg::ST_OUT && out_if.ready && oidx_q == 3'd7) begin
        for (int i = 0; i < 8; i++) h_q[i] <= s256_pkg::start_h(3'(i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign out_if.digest_word = h_q[oidx_q];
  assign out_if.word_index  = oidx_q;
  assign out_if.final_word  = (oidx_q == 3'd7);

  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == s256_pkg::ST_IDLE) else $error("ready outside idle");
  ap_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("input and output overlap");
  ap_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.final_word |=> state_q == s256_pkg::ST_IDLE)
    else $error("no return to idle after digest");
endmodule

FILE: test/sha256_byte_stream_hasher_tb.sv
// Testbench for sha256_byte_stream_hasher: drives message bytes, predicts each digest
// with its own SHA-256 model and checks every word. Depends on s256_pkg and s256_if.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_tb;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  s256_in_if  in_if ();
  s256_out_if out_if ();

  sha256_byte_stream_hasher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]                 hash_h [8];
  logic [7:0]                  blk [64];
  logic [s256_pkg::FillW-1:0]  blk_fill;
  logic [s256_pkg::TotalW-1:0] msg_bytes;
  digest_t                     digest_q [$];
  int                          n_errors = 0;
  int                          n_items = 0;
  int                          next_gap = 0;
  bit                          drain_hold = 1'b0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int j = 0; j < 8; j++) hash_h[j] = HInit[j];
    blk_fill = '0;
    msg_bytes = '0;
  endtask

  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0 = ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = s1 + w[j-7] + s0 + w[j-16];
    end
    for (int j = 0; j < 8; j++) v[j] = hash_h[j];
    for (int j = 0; j < 64; j++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[j] + w[j];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_h[j] = hash_h[j] + v[j];
  endtask

  task automatic absorb_byte(logic [7:0] data, logic present, logic last);
    logic [63:0] bits;
    if (present) begin
      blk[blk_fill] = data;
      blk_fill = blk_fill + 1'b1;
      if (blk_fill == 0) begin
        hash_block();
        msg_bytes = msg_bytes + 61'd64;
      end
    end
    if (last) begin
      bits = {msg_bytes + 61'(blk_fill), 3'b000};
      for (int j = blk_fill; j < 64; j++) blk[j] = 8'h00;
      blk[blk_fill] = s256_pkg::PadByte;
      if (blk_fill > 55) begin
        hash_block();
        for (int j = 0; j < 64; j++) blk[j] = 8'h00;
      end
      for (int j = 0; j < 8; j++) blk[56+j] = bits[63-8*j -: 8];
      hash_block();
      for (int j = 0; j < 8; j++)
        digest_q.push_back(digest_t'{hash_h[j], 3'(j), (j == 7)});
      hash_reset();
    end
  endtask

  task automatic send_word(logic [7:0] data, logic present, logic last);
    repeat (next_gap) @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data_byte <= data;
    in_if.byte_present <= present;
    in_if.last_byte <= last;
    n_items++;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    absorb_byte(data, present, last);
    next_gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) next_gap = 0;
    if (next_gap > 0) in_if.valid <= 1'b0;
  endtask

  task automatic report(string what, digest_t got, digest_t want);
    n_errors++;
    $display("mismatch %s: got %h/%0d/%0d want %h/%0d/%0d", what, got.digest_word,
             got.word_index, got.final_word, want.digest_word, want.word_index,
             want.final_word);
  endtask

  initial begin
    digest_t want, got;
    int gap;
    out_if.ready = 1'b0;
    forever begin
      gap = drain_hold ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_if.valid && out_if.ready)) @(posedge clk_i);
      got = '{out_if.digest_word, out_if.word_index, out_if.final_word};
      if (digest_q.size() == 0) report("unexpected", got, '0);
      else begin
        want = digest_q.pop_front();
        if (got != want) report("digest", got, want);
      end
    end
  end

  task automatic send_message(int len, bit empty_close);
    for (int j = 0; j < len; j++)
      send_word(8'($urandom), 1'b1, !empty_close && j == len - 1);
    if (empty_close || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    if (next_gap == 0) begin
      in_if.valid <= 1'b0;
      next_gap = 1;
    end
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h5a, 1'b0, 1'b1);
  endtask

  task automatic test_block_edges();
    int sizes [4] = '{55, 56, 63, 64};
    foreach (sizes[k]) send_message(sizes[k], 1'b0);
    send_message(64, 1'b1);
  endtask

  task automatic test_quiet_drain();
    drain_hold = 1'b1;
    wait_drained();
    drain_hold = 1'b0;
    send_message(3, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_messages();
    while (n_items < 470) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 20);
      if ($urandom_range(0, 7) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_message(len, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.byte_present = 1'b0;
    in_if.last_byte = 1'b0;
    hash_reset();
    for (int j = 0; j < 64; j++) blk[j] = 8'h00;
    next_gap = $urandom_range(0, 16);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_edges();
    test_quiet_drain();
    test_random_messages();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) $display("sha256_byte_stream_hasher_tb: clean");
    else $display("sha256_byte_stream_hasher_tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("sha256_byte_stream_hasher_tb: errors");
    $finish;
  end
endmodule
